>>> sv/ssc_pkg.sv
package ssc_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned QuotBits = FracBits + 1;
  localparam int unsigned NumBits = 31 + FracBits + 1;
  localparam logic [FracBits:0] OneFix = (FracBits + 1)'(1) << FracBits;

  // fields that ride along the pipeline with each pair
  typedef struct packed {
    logic               hit;
    logic               dgn;
    logic [2:0]         sgn;
    logic [30:0]        mag_x;
    logic [30:0]        mag_y;
    logic [30:0]        mag_z;
    logic signed [30:0] ca_x;
    logic signed [30:0] ca_y;
    logic signed [30:0] ca_z;
    logic [29:0]        ra;
    logic [30:0]        rs;
    logic [31:0]        droot;
    logic [30:0]        pen;
  } carry_t;

endpackage

>>> sv/ssc_front.sv
module ssc_front import ssc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [30:0] ca_x_i,
  input  logic signed [30:0] ca_y_i,
  input  logic signed [30:0] ca_z_i,
  input  logic [29:0]        ra_i,
  input  logic signed [30:0] cb_x_i,
  input  logic signed [30:0] cb_y_i,
  input  logic signed [30:0] cb_z_i,
  input  logic [29:0]        rb_i,
  output logic               valid_o,
  output logic [63:0]        d2_o,
  output carry_t             carry_o
);

  logic [3:0]         vld_q;
  carry_t             c1_d, c1_q, c2_q, c3_q, c4_d, c4_q;
  logic signed [31:0] dx, dy, dz;
  logic [61:0]        sqx_q, sqy_q, sqz_q, rs2_2_q, rs2_3_q;
  logic [63:0]        d2_3_q, d2_4_q;
  logic               hit;

  always_comb begin
    dx = 32'(cb_x_i) - 32'(ca_x_i);
    dy = 32'(cb_y_i) - 32'(ca_y_i);
    dz = 32'(cb_z_i) - 32'(ca_z_i);
    c1_d       = '0;
    c1_d.ca_x  = ca_x_i;
    c1_d.ca_y  = ca_y_i;
    c1_d.ca_z  = ca_z_i;
    c1_d.ra    = ra_i;
    c1_d.rs    = {1'b0, ra_i} + {1'b0, rb_i};
    c1_d.sgn   = {dz[31], dy[31], dx[31]};
    c1_d.mag_x = dx[31] ? 31'(-dx) : dx[30:0];
    c1_d.mag_y = dy[31] ? 31'(-dy) : dy[30:0];
    c1_d.mag_z = dz[31] ? 31'(-dz) : dz[30:0];
  end

  always_comb begin
    hit      = d2_3_q <= {2'b00, rs2_3_q};
    c4_d     = c3_q;
    c4_d.hit = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q    <= c1_d;
      c2_q    <= c1_q;
      sqx_q   <= 62'(c1_q.mag_x) * 62'(c1_q.mag_x);
      sqy_q   <= 62'(c1_q.mag_y) * 62'(c1_q.mag_y);
      sqz_q   <= 62'(c1_q.mag_z) * 62'(c1_q.mag_z);
      rs2_2_q <= 62'(c1_q.rs) * 62'(c1_q.rs);
      c3_q    <= c2_q;
      d2_3_q  <= {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
      rs2_3_q <= rs2_2_q;
      d2_4_q  <= d2_3_q;
      c4_q    <= c4_d;
    end
  end

  assign valid_o = vld_q[3];
  assign d2_o    = d2_4_q;
  assign carry_o = c4_q;

endmodule

>>> sv/ssc_sqrt.sv
module ssc_sqrt import ssc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] d2_i,
  input  carry_t      carry_i,
  output logic        valid_o,
  output carry_t      carry_o
);

  // one root bit per stage, msb first
  logic [SqrtSteps-1:0] vld_q;
  logic [34:0]          rem_in  [SqrtSteps];
  logic [31:0]          root_in [SqrtSteps];
  logic [63:0]          rad_in  [SqrtSteps];
  carry_t               car_in  [SqrtSteps];
  logic [34:0]          rem_d   [SqrtSteps];
  logic [31:0]          root_d  [SqrtSteps];
  logic [34:0]          rem_q   [SqrtSteps];
  logic [31:0]          root_q  [SqrtSteps];
  logic [63:0]          rad_q   [SqrtSteps];
  carry_t               car_q   [SqrtSteps];
  logic [34:0]          t       [SqrtSteps];
  logic [34:0]          trial   [SqrtSteps];

  always_comb begin
    for (int k = 0; k < SqrtSteps; k++) begin
      if (k == 0) begin
        rem_in[k]  = '0;
        root_in[k] = '0;
        rad_in[k]  = d2_i;
        car_in[k]  = carry_i;
      end else begin
        rem_in[k]  = rem_q[k-1];
        root_in[k] = root_q[k-1];
        rad_in[k]  = rad_q[k-1];
        car_in[k]  = car_q[k-1];
      end
      t[k]     = {rem_in[k][32:0], rad_in[k][63:62]};
      trial[k] = {1'b0, root_in[k], 2'b01};
      if (t[k] >= trial[k]) begin
        rem_d[k]  = t[k] - trial[k];
        root_d[k] = {root_in[k][30:0], 1'b1};
      end else begin
        rem_d[k]  = t[k];
        root_d[k] = {root_in[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SqrtSteps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SqrtSteps; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= {rad_in[k][61:0], 2'b00};
        car_q[k]  <= car_in[k];
      end
    end
  end

  always_comb begin
    carry_o       = car_q[SqrtSteps-1];
    carry_o.droot = root_q[SqrtSteps-1];
  end

  assign valid_o = vld_q[SqrtSteps-1];

endmodule

>>> sv/ssc_div.sv
module ssc_div import ssc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [15:0]         degen_i,
  input  carry_t              carry_i,
  output logic                valid_o,
  output carry_t              carry_o,
  output logic [QuotBits-1:0] q_o [3]
);

  // restoring divide, one quotient bit per stage on each of three lanes
  logic [QuotBits:0]    vld_q;
  carry_t               c0_d, c0_q;
  logic [NumBits-1:0]   num [3];
  logic [31:0]          rem0_q [3];
  logic [QuotBits-1:0]  nb0_q  [3];
  logic [30:0]          mags   [3];

  logic [31:0]          rem_in [QuotBits][3];
  logic [QuotBits-1:0]  nb_in  [QuotBits][3];
  logic [QuotBits-1:0]  q_in   [QuotBits][3];
  carry_t               car_in [QuotBits];
  logic [32:0]          t      [QuotBits][3];
  logic [31:0]          rem_d  [QuotBits][3];
  logic [QuotBits-1:0]  q_d    [QuotBits][3];
  logic [31:0]          rem_q  [QuotBits][3];
  logic [QuotBits-1:0]  nb_q   [QuotBits][3];
  logic [QuotBits-1:0]  q_q    [QuotBits][3];
  carry_t               car_q  [QuotBits];

  always_comb begin
    c0_d     = carry_i;
    c0_d.dgn = carry_i.droot <= {16'd0, degen_i};
    c0_d.pen = carry_i.rs - carry_i.droot[30:0];
    mags[0]  = carry_i.mag_x;
    mags[1]  = carry_i.mag_y;
    mags[2]  = carry_i.mag_z;
    for (int l = 0; l < 3; l++) begin
      num[l] = {1'b0, mags[l], {FracBits{1'b0}}} + NumBits'(carry_i.droot[31:1]);
    end
  end

  always_comb begin
    for (int k = 0; k < QuotBits; k++) begin
      car_in[k] = (k == 0) ? c0_q : car_q[k-1];
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          rem_in[k][l] = rem0_q[l];
          nb_in[k][l]  = nb0_q[l];
          q_in[k][l]   = '0;
        end else begin
          rem_in[k][l] = rem_q[k-1][l];
          nb_in[k][l]  = nb_q[k-1][l];
          q_in[k][l]   = q_q[k-1][l];
        end
        t[k][l] = {rem_in[k][l], nb_in[k][l][QuotBits-1]};
        if (t[k][l] >= {1'b0, car_in[k].droot}) begin
          rem_d[k][l] = 32'(t[k][l] - {1'b0, car_in[k].droot});
          q_d[k][l]   = {q_in[k][l][QuotBits-2:0], 1'b1};
        end else begin
          rem_d[k][l] = t[k][l][31:0];
          q_d[k][l]   = {q_in[k][l][QuotBits-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuotBits-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q <= c0_d;
      for (int l = 0; l < 3; l++) begin
        rem0_q[l] <= {1'b0, num[l][NumBits-1:QuotBits]};
        nb0_q[l]  <= num[l][QuotBits-1:0];
      end
      for (int k = 0; k < QuotBits; k++) begin
        car_q[k] <= car_in[k];
        for (int l = 0; l < 3; l++) begin
          rem_q[k][l] <= rem_d[k][l];
          nb_q[k][l]  <= {nb_in[k][l][QuotBits-2:0], 1'b0};
          q_q[k][l]   <= q_d[k][l];
        end
      end
    end
  end

  assign valid_o = vld_q[QuotBits];
  assign carry_o = car_q[QuotBits-1];
  always_comb begin
    for (int l = 0; l < 3; l++) q_o[l] = q_q[QuotBits-1][l];
  end

endmodule

>>> sv/ssc_contact.sv
module ssc_contact import ssc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  carry_t              carry_i,
  input  logic [QuotBits-1:0] q_i [3],
  output logic                valid_o,
  output logic                hit_o,
  output logic [30:0]         pen_o,
  output logic signed [17:0]  n_o [3],
  output logic signed [31:0]  c_o [3]
);

  logic [1:0]         vld_q;
  logic [FracBits:0]  nmag [3];
  logic signed [17:0] n_d  [3];
  logic [46:0]        prod_q [3];
  logic signed [17:0] n1_q [3];
  logic signed [30:0] ca1  [3];
  carry_t             c1_q;
  logic [30:0]        p    [3];
  logic signed [32:0] s    [3];
  logic signed [31:0] sat  [3];
  logic signed [17:0] n2_q [3];
  logic signed [31:0] c2_q [3];
  logic [30:0]        pen_q;
  logic               hit_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (carry_i.dgn) begin
        nmag[l] = (l == 2) ? OneFix : '0;
        n_d[l]  = (l == 2) ? 18'(OneFix) : '0;
      end else begin
        nmag[l] = q_i[l];
        n_d[l]  = carry_i.sgn[l] ? -18'(q_i[l]) : 18'(q_i[l]);
      end
    end
  end

  always_comb begin
    ca1[0] = c1_q.ca_x;
    ca1[1] = c1_q.ca_y;
    ca1[2] = c1_q.ca_z;
    for (int l = 0; l < 3; l++) begin
      p[l] = 31'((prod_q[l] + 47'(1 << (FracBits - 1))) >> FracBits);
      if (n1_q[l] < 0) s[l] = 33'(ca1[l]) - 33'(p[l]);
      else             s[l] = 33'(ca1[l]) + 33'(p[l]);
      // clamp to the signed 32-bit range
      if (s[l][32] != s[l][31]) sat[l] = s[l][32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else                      sat[l] = s[l][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q <= carry_i;
      for (int l = 0; l < 3; l++) begin
        prod_q[l] <= 47'(nmag[l]) * 47'(carry_i.ra);
        n1_q[l]   <= n_d[l];
        n2_q[l]   <= c1_q.hit ? n1_q[l] : '0;
        c2_q[l]   <= c1_q.hit ? sat[l] : '0;
      end
      hit_q <= c1_q.hit;
      pen_q <= c1_q.hit ? c1_q.pen : '0;
    end
  end

  assign valid_o = vld_q[1];
  assign hit_o   = hit_q;
  assign pen_o   = pen_q;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      n_o[l] = n2_q[l];
      c_o[l] = c2_q[l];
    end
  end

endmodule

>>> sv/sphere_sphere_contact.sv
// the pipeline runs from input transfer to result through the front, root, divide and contact units
// throughput: one pair per cycle; the whole pipeline holds while the output is stalled
// the root and divide units resolve one bit per stage, which sets the depth
// reset clears all valid bits and sets degenerate_distance to zero
module sphere_sphere_contact import ssc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_a_x, center_a_y, center_a_z, radius_a, center_b_x, center_b_y, center_b_z, radius_b
  input  logic [247:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // penetration, normal_x, normal_y, normal_z, contact_x, contact_y, contact_z
  output logic [183:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  logic        en;
  logic [15:0] degen_q;
  logic        f_vld, r_vld, d_vld, o_vld;
  logic [63:0] d2;
  carry_t      f_car, r_car, d_car;
  logic [QuotBits-1:0] q [3];
  logic        hit;
  logic [30:0] pen;
  logic signed [17:0] n [3];
  logic signed [31:0] c [3];

  assign en            = !o_vld || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degen_q <= '0;
    end else if (cfg_valid_i) begin
      degen_q <= cfg_data_i;
    end
  end

  ssc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .ca_x_i  (s_axis_tdata[30:0]),
    .ca_y_i  (s_axis_tdata[61:31]),
    .ca_z_i  (s_axis_tdata[92:62]),
    .ra_i    (s_axis_tdata[122:93]),
    .cb_x_i  (s_axis_tdata[153:123]),
    .cb_y_i  (s_axis_tdata[184:154]),
    .cb_z_i  (s_axis_tdata[215:185]),
    .rb_i    (s_axis_tdata[245:216]),
    .valid_o (f_vld),
    .d2_o    (d2),
    .carry_o (f_car)
  );

  ssc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .d2_i    (d2),
    .carry_i (f_car),
    .valid_o (r_vld),
    .carry_o (r_car)
  );

  ssc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_vld),
    .degen_i (degen_q),
    .carry_i (r_car),
    .valid_o (d_vld),
    .carry_o (d_car),
    .q_o     (q)
  );

  ssc_contact u_contact (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld),
    .carry_i (d_car),
    .q_i     (q),
    .valid_o (o_vld),
    .hit_o   (hit),
    .pen_o   (pen),
    .n_o     (n),
    .c_o     (c)
  );

  assign m_axis_tvalid = o_vld;
  assign m_axis_tuser  = hit;
  assign m_axis_tdata  = {3'b000, c[2], c[1], c[0], n[2], n[1], n[0], pen};

endmodule
